[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the maze solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define GMBFS_ASSERT_ALWAYS(label, clk_sig, rstn_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (cond)) \
    else $error("assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define GMBFS_ASSERT_NEXT(label, clk_sig, rstn_sig, trig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

[rtl/core/gmbfs_pkg.sv]
// Package of types and constants for the grid maze BFS solver.
package gmbfs_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;

  localparam logic [1:0] OP_WALL  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] MV_RIGHT = 2'd0;
  localparam logic [1:0] MV_DOWN  = 2'd1;
  localparam logic [1:0] MV_LEFT  = 2'd2;
  localparam logic [1:0] MV_UP    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [CFG_DW-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        wall_dir;
    logic        wall_exists;
    logic [11:0] step_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] path_length;
    logic [5:0]  end_x;
    logic [1:0]  direction;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDW,
    S_CLR,
    S_DEQ,
    S_DEQW,
    S_NBRD,
    S_NBCK,
    S_TC,
    S_TCW,
    S_TW,
    S_TWW
  } state_t;

endpackage

[rtl/core/grid_maze_bfs_solver.sv]
// Top level of the grid maze BFS solver: sequencer, registers and memories.
//
//  channel | ports                        | handshake
//  --------+------------------------------+-----------------------------
//  input   | start, busy, in_item         | taken when start && !busy
//  result  | out_valid, out_item          | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready,        | taken when valid && ready
//          | cfg_index, cfg_data          |
//
// A wall write returns its result in the cycle after it is taken; a path read
// passes through S_RDW first. A solve first sweeps the visited memory, one entry
// a cycle, then handles each dequeued cell (queue read plus four neighbor
// read/check pairs on the wall and visited memories), then makes two trace passes
// back over the arrival moves in the visited memory, the second writing the path.
// Reset is synchronous, active low; it clears control state, sets the sizes to 64.
`include "assert_macros.svh"

module grid_maze_bfs_solver #(
  parameter int MAX_WIDTH  = gmbfs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gmbfs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gmbfs_pkg::in_t                in_item,
  output logic                          out_valid,
  output gmbfs_pkg::out_t               out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmbfs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gmbfs_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XCW   = $clog2(MAX_WIDTH + 1);
  localparam int YCW   = $clog2(MAX_HEIGHT + 1);
  localparam int CAW   = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int RIW   = (CAW > 12) ? CAW : 12;

  function automatic logic [CAW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    cell_addr = CAW'(CAW'(y) * CAW'(MAX_WIDTH) + CAW'(x));
  endfunction

  function automatic logic [XCW-1:0] sat_w(input logic [gmbfs_pkg::CFG_DW-1:0] v);
    if (v == '0) sat_w = XCW'(1);
    else if (int'(v) > MAX_WIDTH) sat_w = XCW'(MAX_WIDTH);
    else sat_w = XCW'(v);
  endfunction

  function automatic logic [YCW-1:0] sat_h(input logic [gmbfs_pkg::CFG_DW-1:0] v);
    if (v == '0) sat_h = YCW'(1);
    else if (int'(v) > MAX_HEIGHT) sat_h = YCW'(MAX_HEIGHT);
    else sat_h = YCW'(v);
  endfunction

  gmbfs_pkg::state_t state_r, state_nxt;

  logic [XCW-1:0] w_r, w_nxt;
  logic [YCW-1:0] h_r, h_nxt;
  logic [LW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CAW-1:0] clr_r, clr_nxt;
  logic [XW-1:0]  x_r, x_nxt, nx_r, nx_nxt, dx_r, dx_nxt, cx_r, cx_nxt;
  logic [YW-1:0]  y_r, y_nxt, ny_r, ny_nxt, dy_r, dy_nxt, cy_r, cy_nxt;
  logic [1:0]     k_r, k_nxt;
  logic           inb_r, inb_nxt, found_r, found_nxt, bad_r, bad_nxt;
  logic [LW-1:0]  len_r, len_nxt, kidx_r, kidx_nxt, slen_r, slen_nxt;
  logic [XW-1:0]  ecol_r, ecol_nxt;
  logic           out_valid_r, out_valid_nxt;
  gmbfs_pkg::out_t out_r, out_nxt;

  logic           rw_we, dw_we, wall_wd, rw_rd, dw_rd;
  logic [CAW-1:0] wall_waddr, wall_raddr;
  logic           vis_we;
  logic [CAW-1:0] vis_waddr, vis_raddr;
  logic [2:0]     vis_wd, vis_rd;
  logic           q_we;
  logic [CAW-1:0] q_waddr, q_raddr;
  logic [XW+YW-1:0] q_wd, q_rd;
  logic           p_we;
  logic [CAW-1:0] p_waddr, p_raddr;
  logic [1:0]     p_wd, p_rd;

  logic           accept, cfg_take;
  logic           nb_inb, nb_open, at_origin;
  logic [XW-1:0]  nb_x, bx;
  logic [YW-1:0]  nb_y, by;
  logic [RIW-1:0] idx_w;

  assign busy      = (state_r != gmbfs_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign idx_w     = RIW'(in_item.step_index);
  assign at_origin = (cx_r == '0) && (cy_r == '0);

  gmbfs_ram #(.W(1), .D(CELLS)) u_rwall (
    .clk(clk), .we(rw_we), .waddr(wall_waddr), .wdata(wall_wd),
    .raddr(wall_raddr), .rdata(rw_rd)
  );
  gmbfs_ram #(.W(1), .D(CELLS)) u_dwall (
    .clk(clk), .we(dw_we), .waddr(wall_waddr), .wdata(wall_wd),
    .raddr(wall_raddr), .rdata(dw_rd)
  );
  gmbfs_ram #(.W(3), .D(CELLS)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
    .raddr(vis_raddr), .rdata(vis_rd)
  );
  gmbfs_ram #(.W(XW+YW), .D(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wd),
    .raddr(q_raddr), .rdata(q_rd)
  );
  gmbfs_ram #(.W(2), .D(CELLS)) u_path (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wd),
    .raddr(p_raddr), .rdata(p_rd)
  );

  // neighbor k of the dequeued cell
  always_comb begin
    nb_x = x_r;
    nb_y = y_r;
    case (k_r)
      gmbfs_pkg::MV_RIGHT: nb_inb = (int'(x_r) + 1 < int'(w_r));
      gmbfs_pkg::MV_DOWN:  nb_inb = (int'(y_r) + 1 < int'(h_r));
      gmbfs_pkg::MV_LEFT:  nb_inb = (x_r != '0);
      gmbfs_pkg::MV_UP:    nb_inb = (y_r != '0);
      default:             nb_inb = 1'b0;
    endcase
    if (nb_inb) begin
      case (k_r)
        gmbfs_pkg::MV_RIGHT: nb_x = x_r + XW'(1);
        gmbfs_pkg::MV_DOWN:  nb_y = y_r + YW'(1);
        gmbfs_pkg::MV_LEFT:  nb_x = x_r - XW'(1);
        gmbfs_pkg::MV_UP:    nb_y = y_r - YW'(1);
        default:             nb_x = x_r;
      endcase
    end
  end

  assign nb_open = inb_r && !(k_r[0] ? dw_rd : rw_rd) && !vis_rd[2];

  // step back along the arrival move of the traced cell
  always_comb begin
    bx = cx_r;
    by = cy_r;
    case (vis_rd[1:0])
      gmbfs_pkg::MV_RIGHT: bx = cx_r - XW'(1);
      gmbfs_pkg::MV_DOWN:  by = cy_r - YW'(1);
      gmbfs_pkg::MV_LEFT:  bx = cx_r + XW'(1);
      gmbfs_pkg::MV_UP:    by = cy_r + YW'(1);
      default:             bx = cx_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmbfs_pkg::S_IDLE: begin
        if (accept && in_item.op == gmbfs_pkg::OP_SOLVE) state_nxt = gmbfs_pkg::S_CLR;
        else if (accept && in_item.op == gmbfs_pkg::OP_READ) state_nxt = gmbfs_pkg::S_RDW;
      end
      gmbfs_pkg::S_RDW: state_nxt = gmbfs_pkg::S_IDLE;
      gmbfs_pkg::S_CLR: begin
        if (clr_r == CAW'(CELLS - 1)) state_nxt = gmbfs_pkg::S_DEQ;
      end
      gmbfs_pkg::S_DEQ: begin
        if (head_r != tail_r) state_nxt = gmbfs_pkg::S_DEQW;
        else if (found_r) state_nxt = gmbfs_pkg::S_TC;
        else state_nxt = gmbfs_pkg::S_IDLE;
      end
      gmbfs_pkg::S_DEQW: state_nxt = gmbfs_pkg::S_NBRD;
      gmbfs_pkg::S_NBRD: state_nxt = gmbfs_pkg::S_NBCK;
      gmbfs_pkg::S_NBCK: begin
        if (k_r == gmbfs_pkg::MV_UP) state_nxt = gmbfs_pkg::S_DEQ;
        else state_nxt = gmbfs_pkg::S_NBRD;
      end
      gmbfs_pkg::S_TC: begin
        if (at_origin) state_nxt = gmbfs_pkg::S_TW;
        else state_nxt = gmbfs_pkg::S_TCW;
      end
      gmbfs_pkg::S_TCW: state_nxt = gmbfs_pkg::S_TC;
      gmbfs_pkg::S_TW: begin
        if (kidx_r == '0) state_nxt = gmbfs_pkg::S_IDLE;
        else state_nxt = gmbfs_pkg::S_TWW;
      end
      gmbfs_pkg::S_TWW: state_nxt = gmbfs_pkg::S_TW;
      default: state_nxt = gmbfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    w_nxt = w_r;  h_nxt = h_r;
    head_nxt = head_r;  tail_nxt = tail_r;  clr_nxt = clr_r;
    x_nxt = x_r;  y_nxt = y_r;  nx_nxt = nx_r;  ny_nxt = ny_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    k_nxt = k_r;  inb_nxt = inb_r;  found_nxt = found_r;  bad_nxt = bad_r;
    len_nxt = len_r;  kidx_nxt = kidx_r;  slen_nxt = slen_r;  ecol_nxt = ecol_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    rw_we = 1'b0;  dw_we = 1'b0;  wall_wd = in_item.wall_exists;
    wall_waddr = cell_addr(XW'(in_item.cell_x), YW'(in_item.cell_y));
    wall_raddr = cell_addr(x_r, y_r);
    vis_we = 1'b0;  vis_waddr = clr_r;  vis_wd = '0;  vis_raddr = cell_addr(nb_x, nb_y);
    q_we = 1'b0;  q_waddr = tail_r[CAW-1:0];  q_wd = {ny_r, nx_r};  q_raddr = head_r[CAW-1:0];
    p_we = 1'b0;  p_waddr = '0;  p_wd = vis_rd[1:0];  p_raddr = idx_w[CAW-1:0];

    if (cfg_take && cfg_index == gmbfs_pkg::CFG_WIDTH) w_nxt = sat_w(cfg_data);
    if (cfg_take && cfg_index == gmbfs_pkg::CFG_HEIGHT) h_nxt = sat_h(cfg_data);

    case (state_r)
      gmbfs_pkg::S_IDLE: begin
        if (accept) begin
          out_nxt.status      = gmbfs_pkg::ST_OK;
          out_nxt.path_length = 12'(slen_r);
          out_nxt.end_x       = 6'(ecol_r);
          out_nxt.direction   = gmbfs_pkg::MV_RIGHT;
          case (in_item.op)
            gmbfs_pkg::OP_WALL: begin
              out_valid_nxt = 1'b1;
              if (int'(in_item.cell_x) < MAX_WIDTH && int'(in_item.cell_y) < MAX_HEIGHT) begin
                rw_we = !in_item.wall_dir;
                dw_we = in_item.wall_dir;
              end
            end
            gmbfs_pkg::OP_SOLVE: begin
              clr_nxt = '0;
            end
            gmbfs_pkg::OP_READ: begin
              bad_nxt = (LW'(in_item.step_index) >= slen_r) || (int'(in_item.step_index) >= CELLS);
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      gmbfs_pkg::S_RDW: begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = bad_r ? gmbfs_pkg::ST_BEYOND : gmbfs_pkg::ST_OK;
        out_nxt.direction = bad_r ? gmbfs_pkg::MV_RIGHT : p_rd;
      end
      gmbfs_pkg::S_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wd    = (clr_r == '0) ? {1'b1, gmbfs_pkg::MV_RIGHT} : 3'b000;
        q_we      = (clr_r == '0);
        q_waddr   = '0;
        q_wd      = '0;
        clr_nxt   = clr_r + CAW'(1);
        head_nxt  = '0;
        tail_nxt  = LW'(1);
        found_nxt = 1'b0;
      end
      gmbfs_pkg::S_DEQ: begin
        if (head_r != tail_r) begin
          head_nxt = head_r + LW'(1);
        end else if (found_r) begin
          cx_nxt  = dx_r;
          cy_nxt  = dy_r;
          len_nxt = '0;
        end else begin
          slen_nxt            = '0;
          ecol_nxt            = '0;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = gmbfs_pkg::ST_NOPATH;
          out_nxt.path_length = '0;
          out_nxt.end_x       = '0;
        end
      end
      gmbfs_pkg::S_DEQW: begin
        x_nxt = q_rd[XW-1:0];
        y_nxt = q_rd[XW+YW-1:XW];
        k_nxt = gmbfs_pkg::MV_RIGHT;
        if (int'(q_rd[XW+YW-1:XW]) == int'(h_r) - 1) begin
          dx_nxt    = q_rd[XW-1:0];
          dy_nxt    = q_rd[XW+YW-1:XW];
          found_nxt = 1'b1;
        end
      end
      gmbfs_pkg::S_NBRD: begin
        inb_nxt    = nb_inb;
        nx_nxt     = nb_x;
        ny_nxt     = nb_y;
        wall_raddr = k_r[1] ? cell_addr(nb_x, nb_y) : cell_addr(x_r, y_r);
        vis_raddr  = cell_addr(nb_x, nb_y);
      end
      gmbfs_pkg::S_NBCK: begin
        if (nb_open) begin
          vis_we    = 1'b1;
          vis_waddr = cell_addr(nx_r, ny_r);
          vis_wd    = {1'b1, k_r};
          q_we      = 1'b1;
          tail_nxt  = tail_r + LW'(1);
        end
        k_nxt = k_r + 2'd1;
      end
      gmbfs_pkg::S_TC: begin
        vis_raddr = cell_addr(cx_r, cy_r);
        if (at_origin) begin
          cx_nxt   = dx_r;
          cy_nxt   = dy_r;
          kidx_nxt = len_r;
        end
      end
      gmbfs_pkg::S_TCW: begin
        cx_nxt  = bx;
        cy_nxt  = by;
        len_nxt = len_r + LW'(1);
      end
      gmbfs_pkg::S_TW: begin
        vis_raddr = cell_addr(cx_r, cy_r);
        if (kidx_r == '0) begin
          slen_nxt            = len_r;
          ecol_nxt            = dx_r;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = gmbfs_pkg::ST_OK;
          out_nxt.path_length = 12'(len_r);
          out_nxt.end_x       = 6'(dx_r);
          out_nxt.direction   = gmbfs_pkg::MV_RIGHT;
        end
      end
      gmbfs_pkg::S_TWW: begin
        p_we     = 1'b1;
        p_waddr  = CAW'(kidx_r - LW'(1));
        p_wd     = vis_rd[1:0];
        cx_nxt   = bx;
        cy_nxt   = by;
        kidx_nxt = kidx_r - LW'(1);
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmbfs_pkg::S_IDLE;
      w_r         <= sat_w(gmbfs_pkg::DIM_RESET);
      h_r         <= sat_h(gmbfs_pkg::DIM_RESET);
      head_r      <= '0;
      tail_r      <= '0;
      found_r     <= 1'b0;
      slen_r      <= '0;
      ecol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      found_r     <= found_nxt;
      slen_r      <= slen_nxt;
      ecol_r      <= ecol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_r  <= clr_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    k_r    <= k_nxt;
    inb_r  <= inb_nxt;
    bad_r  <= bad_nxt;
    len_r  <= len_nxt;
    kidx_r <= kidx_nxt;
    out_r  <= out_nxt;
  end

  `GMBFS_ASSERT_ALWAYS(a_queue_order, clk, rst_n, head_r <= tail_r)
  `GMBFS_ASSERT_ALWAYS(a_result_idle, clk, rst_n, !out_valid || !busy)
  `GMBFS_ASSERT_NEXT(a_wall_resp, clk, rst_n, accept && in_item.op == gmbfs_pkg::OP_WALL, out_valid)

endmodule

[rtl/core/gmbfs_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gmbfs_ram #(
  parameter int W = 1,
  parameter int D = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[bench/grid_maze_bfs_solver_tb.sv]
// Self-checking testbench for the grid maze BFS solver: directed table plus random mazes.
`timescale 1ns / 1ps

module grid_maze_bfs_solver_tb;

  localparam int GW = gmbfs_pkg::MAX_WIDTH_DEF;
  localparam int GH = gmbfs_pkg::MAX_HEIGHT_DEF;
  localparam int NCELL = GW * GH;
  localparam int SPAN = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic WALL_RIGHT = 1'b0;
  localparam logic WALL_DOWN = 1'b1;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       idx;
    logic [6:0]       data;
    gmbfs_pkg::in_t   it;
    bit               typed;
    gmbfs_pkg::out_t  exp;
  } row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  gmbfs_pkg::in_t in_item;
  logic out_valid;
  gmbfs_pkg::out_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [gmbfs_pkg::CFG_IW-1:0] cfg_index;
  logic [gmbfs_pkg::CFG_DW-1:0] cfg_data;

  bit right_wall [NCELL];
  bit down_wall [NCELL];
  logic [1:0] reached_by [NCELL];
  logic [1:0] route [NCELL];
  int route_len;
  int dest_col;
  int cols;
  int rows;

  gmbfs_pkg::out_t result_q [$];
  row_t table_rows [$];
  bit use_typed;
  gmbfs_pkg::out_t typed_res;
  int idle_pct;
  int errors;
  int n_items;
  int n_solves;
  int n_results;

  grid_maze_bfs_solver uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int sat_dim(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int step_back(int c);
    case (reached_by[c])
      gmbfs_pkg::MV_RIGHT: return c - 1;
      gmbfs_pkg::MV_DOWN: return c - GW;
      gmbfs_pkg::MV_LEFT: return c + 1;
      default: return c + GW;
    endcase
  endfunction

  function automatic bit run_search();
    bit seen [NCELL];
    int fifo [NCELL];
    int head;
    int tail;
    int c;
    int x;
    int y;
    int dest;
    int n;
    bit found;
    head = 0;
    tail = 1;
    found = 0;
    dest = 0;
    fifo[0] = 0;
    seen[0] = 1;
    reached_by[0] = gmbfs_pkg::MV_RIGHT;
    while (head < tail) begin
      c = fifo[head];
      head++;
      x = c % GW;
      y = c / GW;
      if (y == rows - 1) begin
        dest = c;
        found = 1;
      end
      if (x + 1 < cols && !right_wall[c] && !seen[c + 1]) begin
        seen[c + 1] = 1; reached_by[c + 1] = gmbfs_pkg::MV_RIGHT; fifo[tail] = c + 1; tail++;
      end
      if (y + 1 < rows && !down_wall[c] && !seen[c + GW]) begin
        seen[c + GW] = 1; reached_by[c + GW] = gmbfs_pkg::MV_DOWN; fifo[tail] = c + GW; tail++;
      end
      if (x > 0 && !right_wall[c - 1] && !seen[c - 1]) begin
        seen[c - 1] = 1; reached_by[c - 1] = gmbfs_pkg::MV_LEFT; fifo[tail] = c - 1; tail++;
      end
      if (y > 0 && !down_wall[c - GW] && !seen[c - GW]) begin
        seen[c - GW] = 1; reached_by[c - GW] = gmbfs_pkg::MV_UP; fifo[tail] = c - GW; tail++;
      end
    end
    if (!found) begin
      route_len = 0;
      dest_col = 0;
      return 0;
    end
    n = 0;
    c = dest;
    while (c != 0 && n < NCELL) begin
      c = step_back(c);
      n++;
    end
    c = dest;
    for (int k = n; k > 0; k--) begin
      route[k - 1] = reached_by[c];
      c = step_back(c);
    end
    route_len = n;
    dest_col = dest % GW;
    return 1;
  endfunction

  function automatic gmbfs_pkg::out_t solve_item(gmbfs_pkg::in_t it);
    gmbfs_pkg::out_t r;
    r.status = gmbfs_pkg::ST_OK;
    r.direction = gmbfs_pkg::MV_RIGHT;
    case (it.op)
      gmbfs_pkg::OP_WALL: begin
        if (it.wall_dir == WALL_DOWN) down_wall[it.cell_y * GW + it.cell_x] = it.wall_exists;
        else right_wall[it.cell_y * GW + it.cell_x] = it.wall_exists;
      end
      gmbfs_pkg::OP_SOLVE: begin
        if (!run_search()) r.status = gmbfs_pkg::ST_NOPATH;
      end
      gmbfs_pkg::OP_READ: begin
        if (it.step_index >= route_len) r.status = gmbfs_pkg::ST_BEYOND;
        else r.direction = route[it.step_index];
      end
      default: ;
    endcase
    r.path_length = route_len[11:0];
    r.end_x = dest_col[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    gmbfs_pkg::out_t e;
    if (rst_n) begin
      if (out_valid) begin
        n_results++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h, none expected", $realtime, out_item);
        end else begin
          e = result_q.pop_front();
          if (out_item.status !== e.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $realtime, e.status, out_item.status);
          end
          if (out_item.path_length !== e.path_length) begin
            errors++;
            $display("%0t: path_length exp %0d got %0d", $realtime, e.path_length,
                     out_item.path_length);
          end
          if (out_item.end_x !== e.end_x) begin
            errors++;
            $display("%0t: end_x exp %0d got %0d", $realtime, e.end_x, out_item.end_x);
          end
          if (out_item.direction !== e.direction) begin
            errors++;
            $display("%0t: direction exp %0d got %0d", $realtime, e.direction,
                     out_item.direction);
          end
        end
      end
      if (start && !busy) begin
        e = solve_item(in_item);
        if (use_typed) e = typed_res;
        result_q = {result_q, e};
        n_items++;
        if (in_item.op == gmbfs_pkg::OP_SOLVE) n_solves++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmbfs_pkg::CFG_WIDTH) cols = sat_dim(cfg_data, GW);
        else if (cfg_index == gmbfs_pkg::CFG_HEIGHT) rows = sat_dim(cfg_data, GH);
      end
    end
  end

  task automatic send_item(gmbfs_pkg::in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (result_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic gmbfs_pkg::in_t wall(int x, int y, logic d, logic ex);
    gmbfs_pkg::in_t it;
    it = '0;
    it.op = gmbfs_pkg::OP_WALL;
    it.cell_x = 6'(x);
    it.cell_y = 6'(y);
    it.wall_dir = d;
    it.wall_exists = ex;
    return it;
  endfunction

  function automatic gmbfs_pkg::in_t op_item(logic [1:0] op, int step);
    gmbfs_pkg::in_t it;
    it = '0;
    it.op = op;
    it.step_index = 12'(step);
    return it;
  endfunction

  function automatic gmbfs_pkg::out_t res(logic [1:0] st, int len, int ex, logic [1:0] d);
    gmbfs_pkg::out_t r;
    r.status = st;
    r.path_length = 12'(len);
    r.end_x = 6'(ex);
    r.direction = d;
    return r;
  endfunction

  function automatic row_t item_row(gmbfs_pkg::in_t it, bit typed, gmbfs_pkg::out_t exp);
    row_t r;
    r = '{default: '0};
    r.it = it;
    r.typed = typed;
    r.exp = exp;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [6:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    table_rows = {table_rows, r};
  endfunction

  task automatic random_item();
    gmbfs_pkg::in_t it;
    int r;
    it = gmbfs_pkg::in_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      it.op = gmbfs_pkg::OP_WALL;
      if ($urandom_range(0, 4) != 0) begin
        it.cell_x = 6'($urandom_range(0, cols - 1));
        it.cell_y = 6'($urandom_range(0, rows - 1));
      end
      it.wall_exists = ($urandom_range(0, 99) < 40);
    end else if (r < 70) begin
      it.op = gmbfs_pkg::OP_SOLVE;
    end else if (r < 92) begin
      it.op = gmbfs_pkg::OP_READ;
      if ($urandom_range(0, 3) != 0) it.step_index = 12'($urandom_range(0, route_len + 1));
    end else begin
      it.op = OP_UNUSED;
    end
    send_item(it);
  endtask

  initial begin
    gmbfs_pkg::out_t none;
    none = '0;
    errors = 0;
    n_items = 0;
    n_solves = 0;
    n_results = 0;
    route_len = 0;
    dest_col = 0;
    cols = GW;
    rows = GH;
    use_typed = 0;
    typed_res = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int c = 0; c < SPAN * SPAN; c++) begin
      send_item(wall(c % SPAN, c / SPAN, WALL_RIGHT, 1'b0));
      send_item(wall(c % SPAN, c / SPAN, WALL_DOWN, 1'b0));
    end

    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 0), 1,
                     res(gmbfs_pkg::ST_BEYOND, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(reg_row(gmbfs_pkg::CFG_WIDTH, 7'd0));
    add_row(reg_row(gmbfs_pkg::CFG_HEIGHT, 7'd127));
    add_row(item_row(wall(0, 0, WALL_DOWN, 1'b1), 1,
                     res(gmbfs_pkg::ST_OK, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(gmbfs_pkg::OP_SOLVE, 0), 1,
                     res(gmbfs_pkg::ST_NOPATH, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 4095), 1,
                     res(gmbfs_pkg::ST_BEYOND, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(wall(0, 0, WALL_DOWN, 1'b0), 0, none));
    add_row(reg_row(gmbfs_pkg::CFG_WIDTH, 7'd127));
    add_row(reg_row(gmbfs_pkg::CFG_HEIGHT, 7'd0));
    add_row(item_row(wall(3, 0, WALL_RIGHT, 1'b1), 1,
                     res(gmbfs_pkg::ST_OK, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(gmbfs_pkg::OP_SOLVE, 0), 1,
                     res(gmbfs_pkg::ST_OK, 3, 3, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 2), 1,
                     res(gmbfs_pkg::ST_OK, 3, 3, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 3), 1,
                     res(gmbfs_pkg::ST_BEYOND, 3, 3, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(wall(63, 63, WALL_DOWN, 1'b1), 1,
                     res(gmbfs_pkg::ST_OK, 3, 3, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(op_item(OP_UNUSED, 4095), 1,
                     res(gmbfs_pkg::ST_OK, 3, 3, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(wall(63, 63, WALL_DOWN, 1'b0), 0, none));
    add_row(item_row(wall(3, 0, WALL_RIGHT, 1'b0), 0, none));
    add_row(reg_row(gmbfs_pkg::CFG_WIDTH, 7'd2));
    add_row(reg_row(gmbfs_pkg::CFG_HEIGHT, 7'd2));
    add_row(item_row(wall(0, 0, WALL_RIGHT, 1'b1), 0, none));
    add_row(item_row(wall(0, 0, WALL_DOWN, 1'b1), 0, none));
    add_row(item_row(op_item(gmbfs_pkg::OP_SOLVE, 0), 1,
                     res(gmbfs_pkg::ST_NOPATH, 0, 0, gmbfs_pkg::MV_RIGHT)));
    add_row(item_row(wall(0, 0, WALL_RIGHT, 1'b0), 0, none));
    add_row(reg_row(gmbfs_pkg::CFG_HEIGHT, 7'd3));
    add_row(item_row(wall(1, 1, WALL_DOWN, 1'b1), 0, none));
    add_row(item_row(op_item(gmbfs_pkg::OP_SOLVE, 0), 0, none));
    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 2), 0, none));
    add_row(item_row(wall(0, 0, WALL_DOWN, 1'b0), 0, none));
    add_row(item_row(wall(1, 1, WALL_DOWN, 1'b0), 0, none));
    add_row(reg_row(gmbfs_pkg::CFG_WIDTH, 7'(SPAN)));
    add_row(reg_row(gmbfs_pkg::CFG_HEIGHT, 7'(SPAN)));
    add_row(item_row(op_item(gmbfs_pkg::OP_SOLVE, 0), 0, none));
    add_row(item_row(op_item(gmbfs_pkg::OP_READ, 5), 0, none));

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        use_typed = table_rows[i].typed;
        typed_res = table_rows[i].exp;
        send_item(table_rows[i].it);
        use_typed = 0;
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 35 : (ph == 1) ? 68 : 0;
      for (int ep = 0; ep < 4; ep++) begin
        write_reg(gmbfs_pkg::CFG_WIDTH, 7'($urandom_range(0, SPAN)));
        write_reg(gmbfs_pkg::CFG_HEIGHT, 7'($urandom_range(0, SPAN)));
        for (int k = 0; k < 4; k++) random_item();
        if (ep == 1) drain();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d items (%0d searches) and %0d results,", n_items, n_solves,
             n_results);
    $display("over clamped sizes, 1-wide and 1-high rows, walled-off and random small grids.");
    if (errors == 0 && result_q.size() == 0) begin
      $display("grid_maze_bfs_solver test passed");
    end else begin
      $display("grid_maze_bfs_solver test failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("grid_maze_bfs_solver test failed");
    $finish;
  end

endmodule
